/* sv/eas_pkg.sv */
// Package for the encoder angle and speed estimator.
// Holds register indexes, reset values, limits and the controller types.
// No dependencies.
package eas_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 17;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ANGLE_OFFSET = 3'd0,
    REG_POLE_COUNT   = 3'd1,
    REG_SPEED_GAIN   = 3'd2,
    REG_SPEED_LIMIT  = 3'd3,
    REG_NEW_WEIGHT   = 3'd4,
    REG_OLD_WEIGHT   = 3'd5
  } reg_index_t;

  localparam logic [13:0] ANGLE_OFFSET_RST = 14'd0;
  localparam logic [6:0]  POLE_COUNT_RST   = 7'd1;
  localparam logic [15:0] SPEED_GAIN_RST   = 16'd7500;
  localparam logic [16:0] SPEED_LIMIT_RST  = 17'd80000;
  localparam logic [15:0] NEW_WEIGHT_RST   = 16'd21845;
  localparam logic [15:0] OLD_WEIGHT_RST   = 16'd45875;

  localparam logic signed [19:0] SPEED_MAX = 20'sd131071;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_GAIN,
    ST_ELEC,
    ST_NEW,
    ST_OLD,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_GAIN,
    MUL_ELEC,
    MUL_NEW,
    MUL_OLD
  } mul_sel_t;

  typedef struct packed {
    logic     load_word;
    logic     calc_angle;
    mul_sel_t mul_sel;
    logic     raw_en;
    logic     elec_en;
    logic     acc_en;
    logic     sum_en;
    logic     out_load;
  } dp_cmd_t;

endpackage

/* sv/eas_ctrl.sv */
// Controller state machine for the encoder angle and speed estimator.
// Sequences the shared multiplier and owns both channel handshakes; uses eas_pkg.
module eas_ctrl
  import eas_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.mul_sel    = MUL_GAIN;
    in_stall       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_word = 1'b1;
          state_next    = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd.calc_angle = 1'b1;
        state_next     = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.mul_sel = MUL_GAIN;
        state_next  = ST_ELEC;
      end
      ST_ELEC: begin
        cmd.mul_sel = MUL_ELEC;
        cmd.raw_en  = 1'b1;
        state_next  = ST_NEW;
      end
      ST_NEW: begin
        cmd.mul_sel = MUL_NEW;
        cmd.elec_en = 1'b1;
        state_next  = ST_OLD;
      end
      ST_OLD: begin
        cmd.mul_sel = MUL_OLD;
        cmd.acc_en  = 1'b1;
        state_next  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/eas_dp.sv */
// Datapath for the encoder angle and speed estimator: configuration registers,
// parity check, angle forming, one shared multiplier and the speed filter; uses eas_pkg.
module eas_dp
  import eas_pkg::*;
#(
  parameter int ANGLE_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [15:0]               response_word,
  input  dp_cmd_t                   cmd,
  output logic [ANGLE_BITS-1:0]     mech_angle,
  output logic [ANGLE_BITS-1:0]     elec_angle,
  output logic signed [17:0]        speed,
  output logic                      parity_error
);

  localparam logic signed [17:0] HALF_TURN = 18'sd1 <<< (ANGLE_BITS - 1);
  localparam logic signed [17:0] TURN      = 18'sd1 <<< ANGLE_BITS;

  logic [13:0] angle_offset;
  logic [6:0]  pole_count;
  logic [15:0] speed_gain;
  logic [16:0] speed_limit;
  logic [15:0] new_weight;
  logic [15:0] old_weight;

  logic [ANGLE_BITS-1:0] held_count;
  logic [ANGLE_BITS-1:0] previous_angle;
  logic signed [17:0]    previous_raw_speed;

  logic                  perr;
  logic [ANGLE_BITS-1:0] mech;
  logic [ANGLE_BITS-1:0] elec;
  logic signed [17:0]    delta;
  logic signed [17:0]    raw;
  logic signed [34:0]    prod;
  logic signed [34:0]    acc;
  logic signed [17:0]    speed_res;

  logic                  word_ok;
  logic [16:0]           mech_diff;
  logic [ANGLE_BITS-1:0] mech_c;
  logic signed [17:0]    delta_c;
  logic signed [17:0]    delta_wrap;
  logic signed [17:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic signed [34:0]    prod_adj;
  logic signed [27:0]    raw_q;
  logic signed [27:0]    lim_pos;
  logic signed [27:0]    lim_neg;
  logic signed [17:0]    raw_next;
  logic signed [35:0]    sum;
  logic signed [35:0]    sum_adj;
  logic signed [19:0]    filt;
  logic signed [17:0]    speed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_offset <= ANGLE_OFFSET_RST;
      pole_count   <= POLE_COUNT_RST;
      speed_gain   <= SPEED_GAIN_RST;
      speed_limit  <= SPEED_LIMIT_RST;
      new_weight   <= NEW_WEIGHT_RST;
      old_weight   <= OLD_WEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ANGLE_OFFSET: angle_offset <= cfg_data[13:0];
        REG_POLE_COUNT:   pole_count   <= cfg_data[6:0];
        REG_SPEED_GAIN:   speed_gain   <= cfg_data[15:0];
        REG_SPEED_LIMIT:  speed_limit  <= cfg_data[16:0];
        REG_NEW_WEIGHT:   new_weight   <= cfg_data[15:0];
        REG_OLD_WEIGHT:   old_weight   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign word_ok    = ~(^response_word);
  assign mech_diff  = 17'(angle_offset) - 17'(held_count);
  assign mech_c     = mech_diff[ANGLE_BITS-1:0];
  assign delta_c    = $signed(18'(mech_c)) - $signed(18'(previous_angle));

  always_comb begin
    delta_wrap = delta_c;
    if (delta_c > HALF_TURN) begin
      delta_wrap = delta_c - TURN;
    end else if (delta_c < -HALF_TURN) begin
      delta_wrap = delta_c + TURN;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_GAIN: begin
        mul_a = delta;
        mul_b = $signed({1'b0, speed_gain});
      end
      MUL_ELEC: begin
        mul_a = $signed(18'(mech));
        mul_b = $signed({10'b0, pole_count});
      end
      MUL_NEW: begin
        mul_a = raw;
        mul_b = $signed({1'b0, new_weight});
      end
      MUL_OLD: begin
        mul_a = previous_raw_speed;
        mul_b = $signed({1'b0, old_weight});
      end
      default: begin
        mul_a = delta;
        mul_b = $signed({1'b0, speed_gain});
      end
    endcase
  end

  assign prod_adj = prod + (prod[34] ? 35'sd255 : 35'sd0);
  assign raw_q    = 28'(prod_adj >>> 8);
  assign lim_pos  = $signed({11'b0, speed_limit});
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (raw_q > lim_pos) begin
      raw_next = lim_pos[17:0];
    end else if (raw_q < lim_neg) begin
      raw_next = lim_neg[17:0];
    end else begin
      raw_next = raw_q[17:0];
    end
  end

  assign sum     = 36'(acc) + 36'(prod);
  assign sum_adj = sum + (sum[35] ? 36'sd65535 : 36'sd0);
  assign filt    = 20'(sum_adj >>> 16);

  always_comb begin
    if (filt > SPEED_MAX) begin
      speed_next = SPEED_MAX[17:0];
    end else if (filt < -SPEED_MAX) begin
      speed_next = 18'(-SPEED_MAX);
    end else begin
      speed_next = filt[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count         <= '0;
      previous_angle     <= '0;
      previous_raw_speed <= '0;
    end else begin
      if (cmd.load_word && word_ok) begin
        held_count <= response_word[ANGLE_BITS-1:0];
      end
      if (cmd.sum_en) begin
        previous_angle     <= mech;
        previous_raw_speed <= raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.load_word) begin
      perr <= ~word_ok;
    end
    if (cmd.calc_angle) begin
      mech  <= mech_c;
      delta <= delta_wrap;
    end
    if (cmd.raw_en) begin
      raw <= raw_next;
    end
    if (cmd.elec_en) begin
      elec <= prod[ANGLE_BITS-1:0];
    end
    if (cmd.acc_en) begin
      acc <= prod;
    end
    if (cmd.sum_en) begin
      speed_res <= speed_next;
    end
    if (cmd.out_load) begin
      mech_angle   <= mech;
      elec_angle   <= elec;
      speed        <= speed_res;
      parity_error <= perr;
    end
  end

endmodule

/* sv/encoder_angle_speed_estimator.sv */
// Top level of the encoder angle and speed estimator.
// Joins eas_ctrl and eas_dp; uses eas_pkg.
//
// Usage:
//   Input channel: response_word with in_valid / in_stall, one sensor frame per
//   transaction. Output channel: mech_angle, elec_angle, speed and
//   parity_error with out_valid / out_stall, one result per input transaction.
//   Configuration: cfg_write with cfg_index and cfg_data, one register per cycle;
//   the user must write registers only while the block is idle; the block does not enforce it.
// Sequencing:
//   A frame steps through ANGLE, GAIN, ELEC, NEW, OLD, SUM and DONE. One shared
//   multiplier is used four times per frame (gain, pole pairs, two filter
//   weights), so the block takes no new frame until the last one is done.
// Reset:
//   Synchronous and active high; restores the register defaults and clears the
//   held count, previous angle and previous raw speed.
// Receiver stall:
//   A pending result holds on the output; the block still takes one further
//   frame, computes it and waits with in_stall high until the output is free.
module encoder_angle_speed_estimator
  import eas_pkg::*;
#(
  parameter int ANGLE_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [15:0]               response_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ANGLE_BITS-1:0]     mech_angle,
  output logic [ANGLE_BITS-1:0]     elec_angle,
  output logic signed [17:0]        speed,
  output logic                      parity_error
);

  dp_cmd_t cmd;

  eas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  eas_dp #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .response_word (response_word),
    .cmd           (cmd),
    .mech_angle    (mech_angle),
    .elec_angle    (elec_angle),
    .speed         (speed),
    .parity_error  (parity_error)
  );

endmodule

/* sim/encoder_angle_speed_estimator_tb.sv */
// Testbench for encoder_angle_speed_estimator: directed and random sensor frames
// checked against an in-bench angle and speed predictor across register settings.
// Depends on eas_pkg and the encoder_angle_speed_estimator RTL.
`timescale 1ns / 1ps

module encoder_angle_speed_estimator_tb;
  import eas_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;
  localparam longint TURN = 64'sd16384;
  localparam longint HALF_TURN = 64'sd8192;
  localparam int SETTLE_CYCLES = 12;
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [13:0]        mech;
    logic [13:0]        elec;
    logic signed [17:0] spd;
    logic               perr;
  } frame_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [15:0]               response_word = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [13:0]               mech_angle;
  logic [13:0]               elec_angle;
  logic signed [17:0]        speed;
  logic                      parity_error;

  logic [13:0] zero_offset = ANGLE_OFFSET_RST;
  logic [6:0]  pole_count  = POLE_COUNT_RST;
  logic [15:0] gain_q8     = SPEED_GAIN_RST;
  logic [16:0] speed_clamp = SPEED_LIMIT_RST;
  logic [15:0] weight_now  = NEW_WEIGHT_RST;
  logic [15:0] weight_last = OLD_WEIGHT_RST;

  logic [13:0] latched_count = '0;
  logic [13:0] last_mech = '0;
  longint      last_raw = 0;

  logic [15:0]   frame_queue[$];
  frame_result_t pending_results[$];
  int            words_accepted = 0;
  int            words_offered = 0;
  int            idle_pct = 28;
  int            hold_start = 0;
  int            hold_served = 0;
  int            hold_off = 0;
  int            fail_count = 0;
  int            stuck_cycles = 0;
  logic [13:0]   walk_count = '0;

  encoder_angle_speed_estimator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .response_word(response_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mech_angle   (mech_angle),
    .elec_angle   (elec_angle),
    .speed        (speed),
    .parity_error (parity_error)
  );

  always #5 clk = ~clk;

  function automatic frame_result_t track_frame(input logic [15:0] word);
    frame_result_t r;
    logic [20:0]   elec_full;
    longint        delta;
    longint        raw;
    longint        filt;
    r.perr = ^word;
    if (!r.perr) begin
      latched_count = word[13:0];
    end
    r.mech = zero_offset - latched_count;
    elec_full = r.mech * pole_count;
    r.elec = elec_full[13:0];
    delta = longint'(r.mech) - longint'(last_mech);
    if (delta > HALF_TURN) begin
      delta = delta - TURN;
    end else if (delta < -HALF_TURN) begin
      delta = delta + TURN;
    end
    raw = delta * longint'(gain_q8) / 256;
    if (raw > longint'(speed_clamp)) begin
      raw = longint'(speed_clamp);
    end else if (raw < -longint'(speed_clamp)) begin
      raw = -longint'(speed_clamp);
    end
    filt = (longint'(weight_now) * raw + longint'(weight_last) * last_raw) / 65536;
    if (filt > longint'(SPEED_MAX)) begin
      filt = longint'(SPEED_MAX);
    end else if (filt < -longint'(SPEED_MAX)) begin
      filt = -longint'(SPEED_MAX);
    end
    last_mech = r.mech;
    last_raw = raw;
    r.spd = filt[17:0];
    return r;
  endfunction

  function automatic logic [15:0] framed(input logic [13:0] count, input logic err_bit);
    logic [15:0] w;
    w = {1'b0, err_bit, count};
    w[15] = ^w[14:0];
    return w;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ANGLE_OFFSET: zero_offset = value[13:0];
      REG_POLE_COUNT:   pole_count = value[6:0];
      REG_SPEED_GAIN:   gain_q8 = value[15:0];
      REG_SPEED_LIMIT:  speed_clamp = value[16:0];
      REG_NEW_WEIGHT:   weight_now = value[15:0];
      REG_OLD_WEIGHT:   weight_last = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input int offset, input int pp, input int gain, input int clamp,
                         input int w_now, input int w_last);
    write_reg(REG_ANGLE_OFFSET, CFG_DATA_BITS'(offset));
    write_reg(REG_POLE_COUNT, CFG_DATA_BITS'(pp));
    write_reg(REG_SPEED_GAIN, CFG_DATA_BITS'(gain));
    write_reg(REG_SPEED_LIMIT, CFG_DATA_BITS'(clamp));
    write_reg(REG_NEW_WEIGHT, CFG_DATA_BITS'(w_now));
    write_reg(REG_OLD_WEIGHT, CFG_DATA_BITS'(w_last));
  endtask

  task automatic queue_random_frames(input int n);
    int          pick;
    logic [15:0] w;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        walk_count = walk_count + 14'($urandom_range(600)) - 14'd300;
      end else if (pick < 75) begin
        walk_count = 14'($urandom_range(16383));
      end
      w = framed(walk_count, $urandom_range(7) == 0);
      if (pick >= 93) begin
        w = 16'($urandom_range(65535));
      end else if (pick >= 85) begin
        w = w ^ (16'd1 << $urandom_range(15));
      end
      frame_queue.push_back(w);
    end
  endtask

  task automatic wait_for_idle();
    @(posedge clk);
    while (frame_queue.size() != 0 || in_valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // accept input transaction and predict its result
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      pending_results.push_back(track_frame(response_word));
      words_accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (words_accepted == words_offered) begin
      if (frame_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        response_word <= frame_queue.pop_front();
        in_valid <= 1'b1;
        words_offered++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_start != hold_served) begin
      hold_served = hold_start;
      hold_off = HOLD_CYCLES;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off = hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    frame_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: mech %0d elec %0d speed %0d parity_error %0b",
                   mech_angle, elec_angle, speed, parity_error);
        end
      end else begin
        e = pending_results.pop_front();
        if (mech_angle !== e.mech || elec_angle !== e.elec || speed !== e.spd ||
            parity_error !== e.perr) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected mech %0d elec %0d speed %0d parity_error %0b",
                     e.mech, e.elec, e.spd, e.perr);
            $display("          actual   mech %0d elec %0d speed %0d parity_error %0b",
                     mech_angle, elec_angle, speed, parity_error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames at reset settings: parity, error bit, half turn and wrap
    frame_queue.push_back(framed(14'd0, 1'b0));
    frame_queue.push_back(framed(14'd16383, 1'b0));
    frame_queue.push_back(framed(14'd16383, 1'b1));
    frame_queue.push_back(16'h8000);
    frame_queue.push_back(16'h4000);
    frame_queue.push_back(16'hC000);
    frame_queue.push_back(16'hFFFF);
    frame_queue.push_back(16'h0001);
    frame_queue.push_back(framed(14'd0, 1'b0));
    frame_queue.push_back(framed(14'd8192, 1'b0));
    frame_queue.push_back(framed(14'd0, 1'b0));
    frame_queue.push_back(framed(14'd8193, 1'b0));
    frame_queue.push_back(framed(14'd1, 1'b0));
    frame_queue.push_back(framed(14'd8194, 1'b0));
    frame_queue.push_back(framed(14'd100, 1'b0));
    frame_queue.push_back(framed(14'd300, 1'b0));
    frame_queue.push_back(framed(14'd301, 1'b0));
    frame_queue.push_back(framed(14'd12000, 1'b0));
    frame_queue.push_back(16'h7FFF);
    frame_queue.push_back(16'h3FFF);
    frame_queue.push_back(framed(14'd5, 1'b0) ^ 16'h0020);
    frame_queue.push_back(framed(14'd5, 1'b1));
    wait_for_idle();

    // top of every range, including pole pairs, and weights summing above one
    set_all(16383, 127, 65535, 131071, 65535, 65535);
    @(posedge clk);
    hold_start++;
    queue_random_frames(250);
    wait_for_idle();

    // zero gain, zero clamp, zero pole pairs, zero weights
    set_all(0, 0, 0, 0, 0, 0);
    queue_random_frames(100);
    wait_for_idle();

    // no idling on either side
    @(posedge clk);
    idle_pct = 0;
    set_all($urandom_range(16383), 64, $urandom_range(65535), $urandom_range(131071),
            65535, 0);
    queue_random_frames(300);
    wait_for_idle();

    @(posedge clk);
    idle_pct = 28;
    write_reg(REG_SPARE, 17'h1FFFF);
    set_all($urandom_range(16383), $urandom_range(127), $urandom_range(65535),
            $urandom_range(131071), $urandom_range(65535), $urandom_range(65535));
    queue_random_frames(300);
    wait_for_idle();

    set_all($urandom_range(16383), $urandom_range(1, 64), $urandom_range(256, 4096),
            $urandom_range(1, 131071), 32768, 32768);
    queue_random_frames(300);
    wait_for_idle();

    set_all(int'(ANGLE_OFFSET_RST), int'(POLE_COUNT_RST), int'(SPEED_GAIN_RST),
            int'(SPEED_LIMIT_RST), int'(NEW_WEIGHT_RST), int'(OLD_WEIGHT_RST));
    queue_random_frames(200);
    wait_for_idle();

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
